FILE: sv/lz_pixel_triple_decoder_top_assert.svh
// Assertion macros for the pixel decoder
`ifndef LZ_PIXEL_TRIPLE_DECODER_TOP_ASSERT_SVH
`define LZ_PIXEL_TRIPLE_DECODER_TOP_ASSERT_SVH

`define LZPD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

`define LZPD_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/lzpd_pkg.sv
`default_nettype none
package lzpd_pkg;

    localparam int unsigned PIX_W = 24;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } lzpd_in_t;

    typedef struct packed {
        logic [23:0] pixel_0;
        logic [23:0] pixel_1;
        logic [23:0] pixel_2;
        logic [23:0] pixel_3;
        logic [2:0]  pixel_count;
        logic [2:0]  status;
        logic        picture_done;
        logic [13:0] image_width;
        logic [13:0] image_height;
        logic        last;
    } lzpd_out_t;

    typedef enum logic [3:0] {
        PH_HEADER, PH_CMD, PH_RUN_COUNT, PH_COPY_COUNT, PH_DIST8,
        PH_DIST_LO, PH_DIST_HI, PH_LITERAL, PH_DONE, PH_ERROR
    } lzpd_phase_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_HEADER = 3'd1, ST_TRUNC = 3'd2, ST_REF = 3'd3,
        ST_OVERRUN = 3'd4, ST_EARLY = 3'd5
    } lzpd_status_t;

    typedef enum logic [1:0] {
        JOB_NONE, JOB_LIT, JOB_COPY
    } lzpd_job_kind_t;

    // One classified request from front to back.
    typedef struct packed {
        lzpd_job_kind_t kind;
        logic [23:0]    literal;
        logic [16:0]    distance;
        logic [7:0]     count;
        logic           overrun;
        logic           lst;
        logic [2:0]     status;
        logic           done;
        logic [13:0]    wout;
        logic [13:0]    hout;
    } lzpd_job_t;

    typedef enum logic [1:0] {
        BK_IDLE, BK_READ, BK_EMIT, BK_FLUSH
    } lzpd_back_state_t;

endpackage
`default_nettype wire

FILE: sv/lzpd_ram.sv
`default_nettype none
module lzpd_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 65536
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: sv/lzpd_front.sv
`default_nettype none
module lzpd_front #(
    parameter int unsigned MAX_DIMENSION  = 8192,
    parameter int unsigned HISTORY_PIXELS = 65536
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire lzpd_pkg::lzpd_in_t in_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output lzpd_pkg::lzpd_job_t    job,
    output logic                   job_valid,
    input  wire logic              job_ready
);
    import lzpd_pkg::*;

    localparam int unsigned HB = $clog2(HISTORY_PIXELS) + 1;

    lzpd_phase_t phase_reg, phase_next;
    logic [2:0]  hidx_reg, hidx_next;
    logic [15:0] w_reg, w_next, h_reg, h_next;
    logic [26:0] pw_reg, pw_next;
    logic [7:0]  cmd_reg, cmd_next, pend_reg, pend_next, dlo_reg, dlo_next;
    logic [15:0] part_reg, part_next;
    logic [1:0]  lph_reg, lph_next;
    logic [2:0]  err_reg, err_next;
    logic [26:0] total_reg;
    logic [26:0] remain;
    lzpd_job_t   j;

    logic [7:0]  b;
    logic        lst, fire;
    logic [16:0] d;
    logic [7:0]  cnt;
    logic [7:0]  pend_m1;

    assign b        = in_data.data_byte;
    assign lst      = in_data.last_byte;
    assign in_ready = job_ready;
    assign fire     = in_valid && job_ready;
    assign remain   = total_reg - pw_reg;
    assign pend_m1  = pend_reg - 8'd1;

    always_ff @(posedge aclk) begin
        total_reg <= 27'(w_reg[13:0] * h_reg[13:0]);
    end

    always_comb begin
        phase_next = phase_reg;
        hidx_next  = hidx_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        pw_next    = pw_reg;
        cmd_next   = cmd_reg;
        pend_next  = pend_reg;
        dlo_next   = dlo_reg;
        part_next  = part_reg;
        lph_next   = lph_reg;
        err_next   = err_reg;
        j          = '0;
        j.kind     = JOB_NONE;
        j.lst      = lst;
        d          = '0;
        cnt        = '0;
        case (phase_reg)
            PH_HEADER: begin
                if (hidx_reg == 3'd4) w_next = {8'd0, b};
                else if (hidx_reg == 3'd5) w_next = {b, w_reg[7:0]};
                else if (hidx_reg == 3'd6) h_next = {8'd0, b};
                else if (hidx_reg == 3'd7) h_next = {b, h_reg[7:0]};
                hidx_next = hidx_reg + 3'd1;
                if (hidx_reg == 3'd7) begin
                    if (w_reg == 16'd0 || h_next == 16'd0 ||
                        32'(w_reg) > MAX_DIMENSION || 32'(h_next) > MAX_DIMENSION) begin
                        phase_next = PH_ERROR;
                        err_next   = ST_HEADER;
                    end else begin
                        phase_next = PH_CMD;
                    end
                end
            end
            PH_CMD: begin
                cmd_next = b;
                if (b == 8'd0) begin
                    if (pw_reg == '0) begin
                        phase_next = PH_ERROR;
                        err_next   = ST_REF;
                    end else begin
                        phase_next = PH_RUN_COUNT;
                    end
                end else if (b == 8'd1 || b == 8'd2) begin
                    phase_next = PH_COPY_COUNT;
                end else if (b == 8'd3) begin
                    pend_next  = 8'd1;
                    phase_next = PH_DIST8;
                end else if (b == 8'd4) begin
                    pend_next  = 8'd1;
                    phase_next = PH_DIST_LO;
                end else begin
                    pend_next  = b - 8'd4;
                    lph_next   = '0;
                    phase_next = PH_LITERAL;
                end
            end
            PH_RUN_COUNT: begin
                d   = 17'd1;
                cnt = b;
            end
            PH_COPY_COUNT: begin
                pend_next  = b;
                phase_next = (cmd_reg == 8'd1) ? PH_DIST8 : PH_DIST_LO;
            end
            PH_DIST8: begin
                d   = {9'd0, b};
                cnt = pend_reg;
            end
            PH_DIST_LO: begin
                dlo_next   = b;
                phase_next = PH_DIST_HI;
            end
            PH_DIST_HI: begin
                d   = {1'b0, b, dlo_reg};
                cnt = pend_reg;
            end
            PH_LITERAL: begin
                if (lph_reg == 2'd0) begin
                    part_next = {b, 8'd0};
                    lph_next  = 2'd1;
                end else if (lph_reg == 2'd1) begin
                    part_next = {part_reg[15:8], b};
                    lph_next  = 2'd2;
                end else begin
                    j.kind    = JOB_LIT;
                    j.literal = {part_reg, b};
                    pw_next   = pw_reg + 27'd1;
                    lph_next  = 2'd0;
                    pend_next = pend_m1;
                    if (pend_m1 == 8'd0) begin
                        phase_next = (pw_reg + 27'd1 >= total_reg) ? PH_DONE : PH_CMD;
                    end else if (pw_reg + 27'd1 >= total_reg) begin
                        phase_next = PH_ERROR;
                        err_next   = ST_OVERRUN;
                    end
                end
            end
            default: ;
        endcase
        if (phase_reg == PH_RUN_COUNT || phase_reg == PH_DIST8 ||
            phase_reg == PH_DIST_HI) begin
            if (phase_reg != PH_RUN_COUNT && (d == '0 || 27'(d) > pw_reg ||
                32'(d) > HISTORY_PIXELS)) begin
                phase_next = PH_ERROR;
                err_next   = ST_REF;
            end else if (27'(cnt) > remain) begin
                j.kind     = JOB_COPY;
                j.distance = d;
                j.count    = remain[7:0];
                pw_next    = total_reg;
                phase_next = PH_ERROR;
                err_next   = ST_OVERRUN;
            end else begin
                j.kind     = (cnt == 8'd0) ? JOB_NONE : JOB_COPY;
                j.distance = d;
                j.count    = cnt;
                pw_next    = pw_reg + 27'(cnt);
                phase_next = (pw_reg + 27'(cnt) >= total_reg) ? PH_DONE : PH_CMD;
            end
        end
        if (phase_next == PH_ERROR) j.status = err_next;
        else if (!lst || phase_next == PH_DONE) j.status = ST_OK;
        else if (phase_next == PH_HEADER) j.status = ST_HEADER;
        else if (phase_next == PH_CMD) j.status = ST_EARLY;
        else j.status = ST_TRUNC;
        j.done = (phase_next == PH_DONE);
        if (phase_next != PH_HEADER && !(phase_next == PH_ERROR && err_next == ST_HEADER)) begin
            j.wout = w_next[13:0];
            j.hout = h_next[13:0];
        end
    end

    assign job       = j;
    assign job_valid = fire;

    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && lst)) begin
            phase_reg <= PH_HEADER;
            hidx_reg  <= '0;
            w_reg     <= '0;
            h_reg     <= '0;
            pw_reg    <= '0;
            cmd_reg   <= '0;
            pend_reg  <= '0;
            dlo_reg   <= '0;
            part_reg  <= '0;
            lph_reg   <= '0;
            err_reg   <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            hidx_reg  <= hidx_next;
            w_reg     <= w_next;
            h_reg     <= h_next;
            pw_reg    <= pw_next;
            cmd_reg   <= cmd_next;
            pend_reg  <= pend_next;
            dlo_reg   <= dlo_next;
            part_reg  <= part_next;
            lph_reg   <= lph_next;
            err_reg   <= err_next;
        end
    end

    logic unused;
    assign unused = ^{HB[0]};
endmodule
`default_nettype wire

FILE: sv/lzpd_back.sv
`default_nettype none
module lzpd_back #(
    parameter int unsigned HISTORY_PIXELS    = 65536,
    parameter int unsigned PIXELS_PER_RESULT = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire lzpd_pkg::lzpd_job_t   job,
    input  wire logic                  job_valid,
    output logic                       job_ready,
    output lzpd_pkg::lzpd_out_t        m_data,
    output logic                       m_valid,
    input  wire logic                  m_ready
);
    import lzpd_pkg::*;

    localparam int unsigned AW = $clog2(HISTORY_PIXELS);
    localparam int unsigned PW = $clog2(PIXELS_PER_RESULT + 1);

    lzpd_back_state_t state_reg, state_next;
    lzpd_job_t        cur_reg;
    logic [AW-1:0]    wptr_reg;
    logic [7:0]       left_reg;
    logic [23:0]      pix_reg [4];
    logic [2:0]       np_reg;
    lzpd_out_t        out_reg;
    logic             out_valid_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [23:0]   wdata, rdata;
    logic          take, out_free, emit_now, pack_full, final_pix, load_out;

    lzpd_ram #(.WIDTH(24), .DEPTH(HISTORY_PIXELS)) u_ram (
        .aclk (aclk), .we (we), .waddr (waddr), .wdata (wdata),
        .raddr (raddr), .rdata (rdata)
    );

    assign out_free  = !out_valid_reg || m_ready;
    assign job_ready = (state_reg == BK_IDLE);
    assign take      = job_valid && job_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign final_pix = (left_reg == 8'd1);
    assign pack_full = (np_reg == 3'(PIXELS_PER_RESULT - 1));
    assign raddr     = AW'(wptr_reg - cur_reg.distance[AW-1:0]);
    assign load_out  = (emit_now && pack_full && !final_pix) ||
                       (state_reg == BK_FLUSH && out_free);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (take && job.kind == JOB_COPY) state_next = BK_READ;
                     else if (take) state_next = BK_FLUSH;
            BK_READ: state_next = BK_EMIT;
            BK_EMIT: if (out_free || !(pack_full || final_pix)) begin
                         state_next = final_pix ? BK_FLUSH : BK_READ;
                     end
            BK_FLUSH: if (out_free) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        emit_now = (state_reg == BK_EMIT) && (out_free || !(pack_full || final_pix));
        we    = emit_now || (take && job.kind == JOB_LIT);
        waddr = wptr_reg;
        wdata = (state_reg == BK_EMIT) ? rdata : job.literal;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            wptr_reg      <= '0;
            np_reg        <= '0;
        end else begin
            state_reg <= state_next;
            if (load_out) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
            if (take) begin
                cur_reg  <= job;
                left_reg <= job.count;
                if (job.kind == JOB_LIT) begin
                    pix_reg[0] <= job.literal;
                    np_reg     <= 3'd1;
                    wptr_reg   <= wptr_reg + AW'(1);
                end else begin
                    np_reg <= '0;
                end
            end
            if (emit_now) begin
                pix_reg[np_reg[1:0]] <= rdata;
                wptr_reg <= wptr_reg + AW'(1);
                left_reg <= left_reg - 8'd1;
                if (pack_full && !final_pix) begin
                    out_reg.pixel_0      <= (np_reg == 3'd0) ? rdata : pix_reg[0];
                    out_reg.pixel_1      <= (np_reg == 3'd1) ? rdata :
                                            ((np_reg > 3'd1) ? pix_reg[1] : '0);
                    out_reg.pixel_2      <= (np_reg == 3'd2) ? rdata :
                                            ((np_reg > 3'd2) ? pix_reg[2] : '0);
                    out_reg.pixel_3      <= (np_reg == 3'd3) ? rdata : '0;
                    out_reg.pixel_count  <= 3'(PIXELS_PER_RESULT);
                    out_reg.status       <= cur_reg.status;
                    out_reg.picture_done <= cur_reg.done;
                    out_reg.image_width  <= cur_reg.wout;
                    out_reg.image_height <= cur_reg.hout;
                    out_reg.last         <= 1'b0;
                    np_reg               <= '0;
                end else begin
                    np_reg <= np_reg + 3'd1;
                end
            end
            if (state_reg == BK_FLUSH && out_free) begin
                out_reg.pixel_0      <= (np_reg > 3'd0) ? pix_reg[0] : '0;
                out_reg.pixel_1      <= (np_reg > 3'd1) ? pix_reg[1] : '0;
                out_reg.pixel_2      <= (np_reg > 3'd2) ? pix_reg[2] : '0;
                out_reg.pixel_3      <= (np_reg > 3'd3) ? pix_reg[3] : '0;
                out_reg.pixel_count  <= np_reg;
                out_reg.status       <= cur_reg.status;
                out_reg.picture_done <= cur_reg.done;
                out_reg.image_width  <= cur_reg.wout;
                out_reg.image_height <= cur_reg.hout;
                out_reg.last         <= 1'b1;
            end
        end
    end

    logic unused;
    assign unused = ^{PW[0], cur_reg.lst, cur_reg.overrun, cur_reg.count, left_reg[0]};

`include "lz_pixel_triple_decoder_top_assert.svh"
    `LZPD_ASSERT(a_cnt_range, aclk, aresetn, m_valid |-> m_data.pixel_count <= 3'(PIXELS_PER_RESULT), "pixel count too large")
    `LZPD_ASSERT(a_hold, aclk, aresetn, (m_valid && !m_ready) |=> $stable(m_data), "stalled result changed")
    `LZPD_ASSERT(a_take_idle, aclk, aresetn, take |-> state_reg == BK_IDLE, "request taken while busy")
    `LZPD_ASSERT_RST(a_rst, aclk, !aresetn |=> !m_valid, "valid after reset")
endmodule
`default_nettype wire

FILE: sv/lz_pixel_triple_decoder_top.sv
`default_nettype none
// Byte-serial LZ decoder producing 24-bit pixels, up to four per result.
// s_ channel: one compressed byte per request, last_byte marks end of file.
// m_ channel: result requests; each input byte gives one or more results,
// the final one flagged by last, carrying status, picture_done and size.
// A header, command, distance or partial-literal byte is taken as a request,
// then its result is loaded into the result register once that is free. In
// a run or copy of N pixels, each pixel is one history RAM read and one
// write, and a full result goes out every fourth pixel.
// The history RAM has one write and one registered read port.
// s_ready is high only while the back end is idle.
// Reset (aresetn low, synchronous) returns the parser to the header.
// A stalled m_ready holds the result register; the back end then stops
// and s_ready stays low until the pending work is delivered.
module lz_pixel_triple_decoder_top #(
    parameter int unsigned MAX_DIMENSION     = 8192,
    parameter int unsigned HISTORY_PIXELS    = 65536,
    parameter int unsigned PIXELS_PER_RESULT = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire lzpd_pkg::lzpd_in_t s_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output lzpd_pkg::lzpd_out_t     m_data,
    output logic                    m_valid,
    input  wire logic               m_ready
);
    import lzpd_pkg::*;

    lzpd_job_t job;
    logic      job_valid, job_ready;

    lzpd_front #(.MAX_DIMENSION(MAX_DIMENSION), .HISTORY_PIXELS(HISTORY_PIXELS)) u_front (
        .aclk (aclk), .aresetn (aresetn), .in_data (s_data), .in_valid (s_valid),
        .in_ready (s_ready), .job (job), .job_valid (job_valid), .job_ready (job_ready)
    );

    lzpd_back #(.HISTORY_PIXELS(HISTORY_PIXELS), .PIXELS_PER_RESULT(PIXELS_PER_RESULT)) u_back (
        .aclk (aclk), .aresetn (aresetn), .job (job), .job_valid (job_valid),
        .job_ready (job_ready), .m_data (m_data), .m_valid (m_valid), .m_ready (m_ready)
    );
endmodule
`default_nettype wire

FILE: sim/lz_pixel_triple_decoder_top_tb.sv
`timescale 1ns / 1ps
module lz_pixel_triple_decoder_top_tb;
    import lzpd_pkg::*;

    localparam int MAX_DIM    = 8192;
    localparam int HIST_PIX   = 65536;
    localparam int PIX_PER    = 4;
    localparam int WDOG_LIMIT = 20000;
    localparam int DRAIN_WAIT = 600;

    class pixel_scoreboard;
        lzpd_phase_t phase;
        logic [2:0]  hdr_idx;
        logic [15:0] width_r, height_r;
        logic [26:0] pix_written;
        logic [7:0]  cmd_code, pending, dist_lo;
        logic [15:0] partial;
        logic [1:0]  lit_phase;
        logic [2:0]  err_code;
        logic [23:0] ring [HIST_PIX];
        logic [23:0] fresh[$];
        lzpd_out_t   pending_results[$];
        int          mismatches;

        function void clear_file();
            phase = PH_HEADER; hdr_idx = '0; width_r = '0; height_r = '0;
            pix_written = '0; cmd_code = '0; pending = '0; dist_lo = '0;
            partial = '0; lit_phase = '0; err_code = ST_OK;
        endfunction

        function int unsigned picture_size();
            return int'(width_r) * int'(height_r);
        endfunction

        function void raise(lzpd_status_t code);
            err_code = code;
            phase = PH_ERROR;
        endfunction

        function void put_pixel(logic [23:0] p);
            ring[pix_written % HIST_PIX] = p;
            pix_written++;
            fresh.push_back(p);
        endfunction

        function void finish_cmd();
            phase = (pix_written >= picture_size()) ? PH_DONE : PH_CMD;
        endfunction

        function void copy_from(int unsigned offset);
            if (offset == 0 || offset > pix_written || offset > HIST_PIX) begin
                raise(ST_REF);
                return;
            end
            for (int j = 0; j < pending; j++) begin
                if (pix_written >= picture_size()) begin
                    raise(ST_OVERRUN);
                    return;
                end
                put_pixel(ring[(pix_written - offset) % HIST_PIX]);
            end
            finish_cmd();
        endfunction

        function void note_request(logic [7:0] b, logic lst);
            logic [23:0] prev;
            logic [2:0]  st;
            logic [13:0] w_out, h_out;
            logic        done;
            int          nres;
            lzpd_out_t   r;
            logic [23:0] px [4];
            fresh.delete();
            case (phase)
                PH_HEADER: begin
                    if (hdr_idx == 4) width_r = {8'h00, b};
                    else if (hdr_idx == 5) width_r[15:8] = b;
                    else if (hdr_idx == 6) height_r = {8'h00, b};
                    else if (hdr_idx == 7) height_r[15:8] = b;
                    hdr_idx = hdr_idx + 3'd1;
                    if (hdr_idx == 0) begin
                        if (width_r == 0 || height_r == 0 || width_r > MAX_DIM ||
                            height_r > MAX_DIM)
                            raise(ST_HEADER);
                        else
                            phase = PH_CMD;
                    end
                end
                PH_CMD: begin
                    cmd_code = b;
                    if (b == 0) begin
                        if (pix_written == 0) raise(ST_REF);
                        else phase = PH_RUN_COUNT;
                    end else if (b == 1 || b == 2) begin
                        phase = PH_COPY_COUNT;
                    end else if (b == 3) begin
                        pending = 8'd1; phase = PH_DIST8;
                    end else if (b == 4) begin
                        pending = 8'd1; phase = PH_DIST_LO;
                    end else begin
                        pending = b - 8'd4; lit_phase = 2'd0; phase = PH_LITERAL;
                    end
                end
                PH_RUN_COUNT: begin
                    prev = ring[(pix_written - 1) % HIST_PIX];
                    for (int j = 0; j < b; j++) begin
                        if (pix_written >= picture_size()) begin
                            raise(ST_OVERRUN);
                            break;
                        end
                        put_pixel(prev);
                    end
                    if (phase != PH_ERROR) finish_cmd();
                end
                PH_COPY_COUNT: begin
                    pending = b;
                    phase = (cmd_code == 1) ? PH_DIST8 : PH_DIST_LO;
                end
                PH_DIST8: copy_from(32'(b));
                PH_DIST_LO: begin
                    dist_lo = b; phase = PH_DIST_HI;
                end
                PH_DIST_HI: copy_from(32'({b, dist_lo}));
                PH_LITERAL: begin
                    if (lit_phase == 0) begin
                        partial = {b, 8'h00}; lit_phase = 2'd1;
                    end else if (lit_phase == 1) begin
                        partial[7:0] = b; lit_phase = 2'd2;
                    end else begin
                        put_pixel({partial, b});
                        lit_phase = 2'd0;
                        pending = pending - 8'd1;
                        if (pending == 0) finish_cmd();
                        else if (pix_written >= picture_size()) raise(ST_OVERRUN);
                    end
                end
                default: ;
            endcase

            if (phase == PH_ERROR) st = err_code;
            else if (!lst || phase == PH_DONE) st = ST_OK;
            else if (phase == PH_HEADER) st = ST_HEADER;
            else if (phase == PH_CMD) st = ST_EARLY;
            else st = ST_TRUNC;
            done = (phase == PH_DONE);
            w_out = '0; h_out = '0;
            if (phase != PH_HEADER && !(phase == PH_ERROR && err_code == ST_HEADER)) begin
                w_out = width_r[13:0]; h_out = height_r[13:0];
            end
            nres = (fresh.size() == 0) ? 1 : (fresh.size() + PIX_PER - 1) / PIX_PER;
            for (int k = 0; k < nres; k++) begin
                r = '0;
                for (int j = 0; j < 4; j++) begin
                    px[j] = '0;
                    if (k * PIX_PER + j < fresh.size()) begin
                        px[j] = fresh[k * PIX_PER + j];
                        r.pixel_count++;
                    end
                end
                r.pixel_0 = px[0]; r.pixel_1 = px[1]; r.pixel_2 = px[2]; r.pixel_3 = px[3];
                r.status = st; r.picture_done = done;
                r.image_width = w_out; r.image_height = h_out;
                r.last = (k + 1 == nres);
                pending_results.push_back(r);
            end
            if (lst) clear_file();
        endfunction

        function void check_result(lzpd_out_t got);
            lzpd_out_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending_results.pop_front();
            if (got.pixel_0 !== want.pixel_0 || got.pixel_1 !== want.pixel_1 ||
                got.pixel_2 !== want.pixel_2 || got.pixel_3 !== want.pixel_3 ||
                got.pixel_count !== want.pixel_count || got.status !== want.status ||
                got.picture_done !== want.picture_done ||
                got.image_width !== want.image_width ||
                got.image_height !== want.image_height || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h actual %h", want, got);
            end
        endfunction
    endclass

    logic      aclk, aresetn;
    lzpd_in_t  s_data;
    logic      s_valid, s_ready;
    lzpd_out_t m_data;
    logic      m_valid, m_ready;

    pixel_scoreboard sb;
    int send_idle, recv_idle, hold_cycles, quiet_cycles;
    logic [7:0] file_q[$];

    lz_pixel_triple_decoder_top dut (
        .aclk(aclk), .aresetn(aresetn), .s_data(s_data), .s_valid(s_valid),
        .s_ready(s_ready), .m_data(m_data), .m_valid(m_valid), .m_ready(m_ready)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b, logic lst);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_byte: b, last_byte: lst};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(b, lst);
    endtask

    task automatic put_byte(int v);
        file_q.push_back(v[7:0]);
    endtask

    task automatic send_file();
        foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
        file_q.delete();
    endtask

    task automatic put_header(int w, int h);
        put_byte(255); put_byte(0);
        put_byte($urandom_range(255)); put_byte($urandom_range(255));
        put_byte(w); put_byte(w >> 8);
        put_byte(h); put_byte(h >> 8);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic build_random_file();
        int w, h, total, made, left, n, d, kind;
        if ($urandom_range(4) == 0) begin
            w = $urandom_range(1, 20); h = $urandom_range(1, 20);
        end else begin
            w = $urandom_range(1, 6); h = $urandom_range(1, 6);
        end
        if ($urandom_range(19) == 0) w = $urandom_range(1) ? 0 : 8193 + $urandom_range(50000);
        put_header(w, h);
        total = w * h;
        made = 0;
        if (total == 0) put_byte($urandom_range(255));
        while (made < total && file_q.size() < 30) begin
            left = total - made;
            if ($urandom_range(29) == 0) begin
                put_byte($urandom_range(255));
                continue;
            end
            kind = (made == 0) ? 0 : $urandom_range(5);
            n = $urandom_range(1, left > 255 ? 255 : left);
            if ($urandom_range(15) == 0) n = n + $urandom_range(1, 3);
            if (n > 255) n = 255;
            d = $urandom_range(1, made > 255 ? 255 : (made < 1 ? 1 : made));
            if ($urandom_range(29) == 0) d = made + 1;
            case (kind)
                0: begin
                    if (n > 8) n = 8;
                    put_byte(n + 4);
                    repeat (3 * n) put_byte($urandom_range(255));
                end
                1: begin put_byte(0); put_byte(n); end
                2: begin put_byte(1); put_byte(n); put_byte(d); end
                3: begin
                    d = $urandom_range(1, made);
                    put_byte(2); put_byte(n);
                    put_byte(d); put_byte(d >> 8);
                end
                4: begin n = 1; put_byte(3); put_byte(d); end
                default: begin
                    n = 1;
                    put_byte(4); put_byte(d); put_byte(d >> 8);
                end
            endcase
            made += n;
        end
        if ($urandom_range(7) == 0 && file_q.size() > 10)
            repeat ($urandom_range(1, 3)) void'(file_q.pop_back());
        if ($urandom_range(7) == 0)
            repeat ($urandom_range(1, 3)) put_byte($urandom_range(255));
    endtask

    task automatic random_files(int n_bytes);
        int sent;
        sent = 0;
        while (sent < n_bytes) begin
            build_random_file();
            sent += file_q.size();
            send_file();
        end
    endtask

    initial begin
        sb = new();
        sb.clear_file();
        sb.mismatches = 0;
        aclk = 0; aresetn = 0; s_valid = 0; s_data = '0; m_ready = 0;
        hold_cycles = 0; quiet_cycles = 0;
        send_idle = 33; recv_idle = 56;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // bad headers, header cut short
        put_header(0, 1); put_byte(255); send_file();
        put_header(MAX_DIM + 1, 1); send_file();
        file_q = '{8'h00, 8'hff, 8'h55}; send_file();
        // largest picture, run before any pixel
        put_header(MAX_DIM, MAX_DIM); put_byte(0); put_byte(7); send_file();
        // literal then zero distance
        put_header(2, 2);
        put_byte(5); put_byte(255); put_byte(255);
        put_byte(255); put_byte(3); put_byte(0); send_file();
        // full run to fill a 16x16 picture, then an ignored byte
        put_header(16, 16);
        put_byte(5); repeat (3) put_byte(0);
        put_byte(0); put_byte(255); put_byte('haa); send_file();
        // literals pending when the picture fills
        put_header(2, 1); put_byte(7);
        repeat (6) put_byte($urandom_range(255));
        put_byte(1); send_file();
        // truncated literal, then ended early
        put_header(4, 4); put_byte(5); put_byte('haa); send_file();
        put_header(4, 4); put_byte(5);
        put_byte(1); put_byte(2); put_byte(3); send_file();
        // far 16-bit distance, then 16-bit copy overlap
        put_header(4, 4); put_byte(5); repeat (3) put_byte('h5a);
        put_byte(4); put_byte(255); put_byte(255); send_file();
        put_header(4, 2); put_byte(6); repeat (6) put_byte($urandom_range(255));
        put_byte(2); put_byte(9); put_byte(2); put_byte(0);
        send_file();
        wait_drained();

        random_files(10);
        wait_drained();
        send_idle = 56; recv_idle = 33;
        random_files(10);
        wait_drained();
        send_idle = 0; recv_idle = 0;
        hold_cycles = 400;
        put_header(20, 20);
        put_byte(13);
        repeat (27) put_byte($urandom_range(255));
        put_byte(0); put_byte(200);
        send_file();
        wait_drained();
        random_files(10);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+sv
sv/lzpd_pkg.sv
sv/lzpd_ram.sv
sv/lzpd_front.sv
sv/lzpd_back.sv
sv/lz_pixel_triple_decoder_top.sv
sim/lz_pixel_triple_decoder_top_tb.sv
